>>> rtl/psa_pkg.sv
`default_nettype none
package psa_pkg;
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int MAX_NODES_DEF = 16;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_BLOCK = 2'd1;
	localparam logic [1:0] ST_UNOPENED = 2'd2;
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;
endpackage
`default_nettype wire

>>> rtl/pooled_slot_allocator_top.sv
`default_nettype none
// Pooled slot allocator.
// The request channel (req_valid/req_stall) carries one item: req_type, and for a
// free, block_slot and node_index. The result channel (rsp_valid/rsp_stall)
// returns exactly one item per request: status, got_block, got_node and the pool
// totals free_total and open_blocks after the request.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes slots_per_block
// and reinitializes the pool. It is only taken while no request is in flight, and
// requests are stalled while cfg_valid is high.
// One request is worked on at a time by a small sequencer around a single node RAM.
// A free goes from S_FREE straight to its result when the block's free list is
// empty, and through S_FRD otherwise. Releasing a block walks the block order
// ring to unlink it, one block per cycle. An alloc walks the block order ring,
// visiting 1 to MAX_BLOCKS blocks. If it finds a free node it reads it in S_ARD1
// and S_ARD2; else it opens a new block in S_SCAN and rebuilds that block's ring
// of slots_per_block - 1 nodes in S_BUILD, one node per cycle.
// After reset or a configuration write the ring of block 0 is rebuilt, one node per
// cycle, and requests are stalled then. A result waits in the output register
// while rsp_stall is high; the next request item is accepted at the earliest in
// the cycle after the result is taken.
module pooled_slot_allocator_top #(
	parameter int MAX_BLOCKS = psa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_NODES = psa_pkg::MAX_NODES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic req_type,
	input wire logic [3:0] block_slot,
	input wire logic [3:0] node_index,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output logic [1:0] status,
	output logic [3:0] got_block,
	output logic [3:0] got_node,
	output logic [8:0] free_total,
	output logic [4:0] open_blocks,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [4:0] cfg_data
);
	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int AW = BW + NW;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_WALK, S_ARD1, S_ARD2, S_SCAN, S_BUILD,
		S_FREE, S_FRD, S_UNLINK, S_RESP
	} state_t;

	state_t state_q;
	logic [4:0] spb_q, nper_q;
	logic open_q [MAX_BLOCKS];
	logic [4:0] cnt_q [MAX_BLOCKS];
	logic [NW-1:0] head_q [MAX_BLOCKS];
	logic empty_q [MAX_BLOCKS];
	logic [BW-1:0] ord_q [MAX_BLOCKS];
	logic [8:0] tot_q;
	logic [4:0] nblk_q;
	logic [BW-1:0] b_q, start_q;
	logic [NW-1:0] n_q, node_q;
	logic [4:0] steps_q;
	logic [1:0] st_q;
	logic [3:0] gb_q, gn_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [NW-1:0] wdata, rdata;

	// Second write of a free insert: head.next <= node, in the cycle after S_FRD.
	logic fix_q;
	logic [AW-1:0] fix_addr_q;
	logic [NW-1:0] fix_data_q;

	psa_node_ram #(.DEPTH(MAX_BLOCKS * MAX_NODES), .AW(AW), .DW(NW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [4:0] nclamp;
	always_comb begin
		nclamp = (spb_q == 5'd0) ? 5'd1 : spb_q;
		if (32'(nclamp) > MAX_NODES) begin
			nclamp = 5'(MAX_NODES);
		end
	end

	// Build step: node n_q of block b_q links to the next node of a ring of
	// steps_q nodes.
	logic [4:0] n_inc;
	assign n_inc = 5'(n_q) + 5'd1;

	always_comb begin
		we = 1'b0;
		waddr = {b_q, n_q};
		wdata = '0;
		raddr = {b_q, head_q[b_q]};
		case (state_q)
			S_INIT: begin
				// The root ring is always block 0, sized by the new register value.
				we = 1'b1;
				waddr = {{BW{1'b0}}, n_q};
				wdata = (n_inc < nclamp) ? NW'(n_inc) : '0;
			end
			S_BUILD: begin
				we = 1'b1;
				wdata = (n_inc < steps_q) ? NW'(n_inc) : '0;
			end
			S_ARD2: begin
				// head.next = node.next
				we = (cnt_q[b_q] != 5'd1) && !empty_q[b_q];
				waddr = {b_q, head_q[b_q]};
				wdata = rdata;
			end
			S_FRD: begin
				we = 1'b1;
				waddr = {b_q, node_q};
				wdata = rdata;
			end
			S_FREE: begin
				we = empty_q[b_q];
				waddr = {b_q, node_q};
				wdata = node_q;
			end
			S_ARD1: begin
				raddr = {b_q, rdata};
			end
			default: begin
			end
		endcase
		if (fix_q) begin
			we = 1'b1;
			waddr = fix_addr_q;
			wdata = fix_data_q;
		end
	end

	assign req_stall = (state_q != S_IDLE) || rsp_valid || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) && !rsp_valid;
	assign status = st_q;
	assign got_block = gb_q;
	assign got_node = gn_q;
	assign free_total = tot_q;
	assign open_blocks = nblk_q;

	logic [BW-1:0] first_closed;
	logic any_closed;
	always_comb begin
		first_closed = '0;
		any_closed = 1'b0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				first_closed = BW'(i);
				any_closed = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			spb_q <= 5'd16;
			nper_q <= 5'd1;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				open_q[i] <= (i == 0);
				cnt_q[i] <= '0;
				head_q[i] <= '0;
				empty_q[i] <= 1'b0;
				ord_q[i] <= '0;
			end
			tot_q <= '0;
			nblk_q <= 5'd1;
			b_q <= '0;
			start_q <= '0;
			n_q <= '0;
			node_q <= '0;
			steps_q <= '0;
			st_q <= psa_pkg::ST_OK;
			gb_q <= '0;
			gn_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (n_q == '0) begin
						nper_q <= nclamp;
						steps_q <= nclamp;
						for (int i = 0; i < MAX_BLOCKS; i++) begin
							open_q[i] <= (i == 0);
							cnt_q[i] <= (i == 0) ? nclamp : 5'd0;
							head_q[i] <= '0;
							empty_q[i] <= 1'b0;
							ord_q[i] <= '0;
						end
						tot_q <= 9'(nclamp);
						nblk_q <= 5'd1;
						b_q <= '0;
					end
					if (n_inc >= nclamp) begin
						n_q <= '0;
						state_q <= S_IDLE;
					end else begin
						n_q <= NW'(n_inc);
					end
				end
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						spb_q <= cfg_data;
						n_q <= '0;
						state_q <= S_INIT;
					end else if (req_valid && !req_stall) begin
						gb_q <= '0;
						gn_q <= '0;
						if (req_type == psa_pkg::REQ_ALLOC) begin
							st_q <= psa_pkg::ST_OK;
							b_q <= ord_q[0];
							start_q <= ord_q[0];
							steps_q <= '0;
							state_q <= S_WALK;
						end else if (32'(block_slot) >= MAX_BLOCKS
							|| !open_q[BW'(block_slot)]) begin
							st_q <= psa_pkg::ST_UNOPENED;
							state_q <= S_RESP;
						end else begin
							st_q <= psa_pkg::ST_OK;
							node_q <= NW'(node_index);
							if (block_slot != '0
								&& cnt_q[BW'(block_slot)] == nper_q - 5'd1) begin
								b_q <= '0;
								start_q <= BW'(block_slot);
								steps_q <= '0;
								state_q <= S_UNLINK;
							end else begin
								b_q <= BW'(block_slot);
								state_q <= S_FREE;
							end
						end
					end
				end
				S_WALK: begin
					if (cnt_q[b_q] != 5'd0) begin
						state_q <= S_ARD1;
					end else if (ord_q[b_q] == start_q
						|| 32'(steps_q) + 1 >= MAX_BLOCKS) begin
						state_q <= S_SCAN;
					end else begin
						b_q <= ord_q[b_q];
						steps_q <= steps_q + 5'd1;
					end
				end
				S_ARD1: begin
					// RAM now returns head.next; address its next.
					if (cnt_q[b_q] == 5'd1 || empty_q[b_q]) begin
						node_q <= head_q[b_q];
						empty_q[b_q] <= 1'b1;
					end else begin
						node_q <= rdata;
					end
					state_q <= S_ARD2;
				end
				S_ARD2: begin
					cnt_q[b_q] <= cnt_q[b_q] - 5'd1;
					tot_q <= tot_q - 9'd1;
					gb_q <= 4'(b_q);
					gn_q <= 4'(node_q);
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (!any_closed) begin
						st_q <= psa_pkg::ST_NO_BLOCK;
						state_q <= S_RESP;
					end else begin
						b_q <= first_closed;
						open_q[first_closed] <= 1'b1;
						cnt_q[first_closed] <= nper_q - 5'd1;
						head_q[first_closed] <= '0;
						empty_q[first_closed] <= (nper_q == 5'd1);
						ord_q[first_closed] <= ord_q[0];
						ord_q[0] <= first_closed;
						tot_q <= tot_q + 9'(nper_q) - 9'd1;
						nblk_q <= nblk_q + 5'd1;
						gb_q <= 4'(first_closed);
						gn_q <= 4'(nper_q - 5'd1);
						steps_q <= nper_q - 5'd1;
						n_q <= '0;
						state_q <= (nper_q == 5'd1) ? S_RESP : S_BUILD;
					end
				end
				S_BUILD: begin
					if (n_inc >= steps_q) begin
						state_q <= S_RESP;
					end else begin
						n_q <= NW'(n_inc);
					end
				end
				S_FREE: begin
					if (empty_q[b_q]) begin
						head_q[b_q] <= node_q;
						empty_q[b_q] <= 1'b0;
						cnt_q[b_q] <= cnt_q[b_q] + 5'd1;
						tot_q <= tot_q + 9'd1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					// node.next = head.next written by the RAM port; head.next
					// gets node in the second write in the next cycle.
					state_q <= S_RESP;
					cnt_q[b_q] <= cnt_q[b_q] + 5'd1;
					tot_q <= tot_q + 9'd1;
				end
				S_UNLINK: begin
					if (ord_q[b_q] == start_q) begin
						ord_q[b_q] <= ord_q[start_q];
						open_q[start_q] <= 1'b0;
						cnt_q[start_q] <= '0;
						empty_q[start_q] <= 1'b0;
						tot_q <= tot_q - (9'(nper_q) - 9'd1);
						nblk_q <= nblk_q - 5'd1;
						state_q <= S_RESP;
					end else if (ord_q[b_q] == '0
						|| 32'(steps_q) + 1 >= MAX_BLOCKS) begin
						open_q[start_q] <= 1'b0;
						cnt_q[start_q] <= '0;
						empty_q[start_q] <= 1'b0;
						tot_q <= tot_q - (9'(nper_q) - 9'd1);
						nblk_q <= nblk_q - 5'd1;
						state_q <= S_RESP;
					end else begin
						b_q <= ord_q[b_q];
						steps_q <= steps_q + 5'd1;
					end
				end
				S_RESP: begin
					rsp_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_q <= 1'b0;
		end else begin
			fix_q <= (state_q == S_FRD);
		end
	end
	always_ff @(posedge clk) begin
		fix_addr_q <= {b_q, head_q[b_q]};
		fix_data_q <= node_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> nblk_q != 5'd0)
		else $error("root block lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> state_q == S_INIT)
		else $error("config write did not reinitialize");
endmodule
`default_nettype wire

>>> rtl/psa_node_ram.sv
`default_nettype none
module psa_node_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8,
	parameter int DW = 4
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [DW-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int NBLK = 16;
	localparam int NNODE = 16;
	// The run is cut off here.
	localparam int CYCLE_LIMIT = 1000000;
	// Longest quiet time the block may still be busy after its last result.
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic req_type;
	logic [3:0] block_slot;
	logic [3:0] node_index;
	logic rsp_valid;
	logic rsp_stall;
	logic [1:0] status;
	logic [3:0] got_block;
	logic [3:0] got_node;
	logic [8:0] free_total;
	logic [4:0] open_blocks;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;

	pooled_slot_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.block_slot(block_slot),
		.node_index(node_index),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.got_block(got_block),
		.got_node(got_node),
		.free_total(free_total),
		.open_blocks(open_blocks),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// One expected result item.
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] blk;
		logic [3:0] node;
		logic [8:0] free_total;
		logic [4:0] open_blocks;
	} slot_result_t;

	// A slot handed out by the pool and not yet given back.
	typedef struct packed {
		logic [3:0] blk;
		logic [3:0] node;
	} slot_ref_t;

	slot_result_t pending_results[$];
	slot_ref_t live_slots[$];

	// Shadow copy of the pool.
	int unsigned pool_nper;
	bit pool_open[NBLK];
	logic [4:0] pool_free_cnt[NBLK];
	logic [4:0] pool_head[NBLK];
	bit pool_empty[NBLK];
	logic [3:0] pool_link[NBLK*NNODE];
	logic [3:0] pool_order[NBLK];
	logic [8:0] pool_free_total;
	logic [4:0] pool_blocks;

	int fail_count = 0;
	int cycle_count = 0;
	bit quiet = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Fills the free ring of one block with nodes 0 .. count-1.
	function automatic void fill_ring(int unsigned b, int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			pool_link[b*NNODE + i] = (i + 1 < count) ? 4'(i + 1) : 4'd0;
		pool_head[b] = '0;
		pool_free_cnt[b] = 5'(count);
		pool_empty[b] = (count == 0);
	endfunction

	// Brings the shadow pool to its state after a register write or reset.
	function automatic void pool_init(logic [4:0] spb);
		int unsigned n;
		n = spb;
		if (n == 0) n = 1;
		if (n > NNODE) n = NNODE;
		pool_nper = n;
		for (int i = 0; i < NBLK; i++) begin
			pool_open[i] = 0;
			pool_free_cnt[i] = '0;
			pool_head[i] = '0;
			pool_empty[i] = 0;
			pool_order[i] = '0;
		end
		for (int i = 0; i < NBLK*NNODE; i++) pool_link[i] = '0;
		pool_open[0] = 1;
		fill_ring(0, n);
		pool_free_total = 9'(n);
		pool_blocks = 5'd1;
	endfunction

	// Takes a slot: first block in ring order with a free node, else opens
	// the lowest unopened block behind the root.
	function automatic void pool_take(output slot_result_t r);
		int unsigned b, h, nd, nb;
		r = '0;
		b = pool_order[0];
		for (int steps = 0; steps < NBLK; steps++) begin
			if (pool_free_cnt[b] != 0) begin
				h = pool_head[b] % NNODE;
				if (pool_free_cnt[b] == 1 || pool_empty[b]) begin
					nd = h;
					pool_empty[b] = 1;
				end else begin
					nd = pool_link[b*NNODE + h];
					pool_link[b*NNODE + h] = pool_link[b*NNODE + nd];
				end
				pool_free_cnt[b] = pool_free_cnt[b] - 5'd1;
				pool_free_total = pool_free_total - 9'd1;
				r.status = psa_pkg::ST_OK;
				r.blk = 4'(b);
				r.node = 4'(nd);
				return;
			end
			b = pool_order[b];
			if (b == pool_order[0]) break;
		end
		for (nb = 0; nb < NBLK; nb++)
			if (!pool_open[nb]) break;
		if (nb >= NBLK) begin
			r.status = psa_pkg::ST_NO_BLOCK;
			return;
		end
		pool_open[nb] = 1;
		fill_ring(nb, pool_nper - 1);
		pool_order[nb] = pool_order[0];
		pool_order[0] = 4'(nb);
		pool_free_total = pool_free_total + 9'(pool_nper - 1);
		pool_blocks = pool_blocks + 5'd1;
		r.status = psa_pkg::ST_OK;
		r.blk = 4'(nb);
		r.node = 4'(pool_nper - 1);
	endfunction

	// Gives a node back; a non-root block that becomes wholly free is closed.
	function automatic logic [1:0] pool_give(int unsigned b, int unsigned nd);
		int unsigned p, h;
		if (!pool_open[b]) return psa_pkg::ST_UNOPENED;
		if (b != 0 && pool_free_cnt[b] == 5'(pool_nper - 1)) begin
			p = 0;
			for (int steps = 0; steps < NBLK; steps++) begin
				if (pool_order[p] == b) begin
					pool_order[p] = pool_order[b];
					break;
				end
				p = pool_order[p];
				if (p == 0) break;
			end
			pool_open[b] = 0;
			pool_free_cnt[b] = '0;
			pool_empty[b] = 0;
			pool_free_total = pool_free_total - 9'(pool_nper - 1);
			pool_blocks = pool_blocks - 5'd1;
			return psa_pkg::ST_OK;
		end
		if (pool_empty[b]) begin
			pool_link[b*NNODE + nd] = 4'(nd);
			pool_head[b] = 5'(nd);
			pool_empty[b] = 0;
		end else begin
			h = pool_head[b] % NNODE;
			pool_link[b*NNODE + nd] = pool_link[b*NNODE + h];
			pool_link[b*NNODE + h] = 4'(nd);
		end
		pool_free_cnt[b] = pool_free_cnt[b] + 5'd1;
		pool_free_total = pool_free_total + 9'd1;
		return psa_pkg::ST_OK;
	endfunction

	// Sends one request item, with a random gap before it unless quiet.
	// Valid stays high afterwards so back-to-back items need no gap.
	task automatic send_request(logic kind, logic [3:0] b, logic [3:0] nd);
		slot_result_t r;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_valid = 1;
		req_type = kind;
		block_slot = b;
		node_index = nd;
		do @(posedge clk); while (req_stall);
		if (kind == psa_pkg::REQ_ALLOC) begin
			pool_take(r);
			if (r.status == psa_pkg::ST_OK) live_slots.push_back({r.blk, r.node});
		end else begin
			r = '0;
			r.status = pool_give(b, nd);
		end
		r.free_total = pool_free_total;
		r.open_blocks = pool_blocks;
		pending_results.push_back(r);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes slots_per_block once the block has gone quiet.
	task automatic write_slots(logic [4:0] spb);
		wait_idle();
		cfg_valid = 1;
		cfg_data = spb;
		do @(posedge clk); while (!cfg_ready);
		pool_init(spb);
		live_slots.delete();
		@(negedge clk);
		cfg_valid = 0;
		cfg_data = 5'($urandom);
	endtask

	task automatic free_live(int unsigned idx);
		slot_ref_t s;
		s = live_slots[idx];
		live_slots.delete(idx);
		send_request(psa_pkg::REQ_FREE, s.blk, s.node);
	endtask

	// Extremes of the fields at reset: alloc, frees to unopened blocks, free to the
	// root, the highest node index, and a block opened then released.
	task automatic test_directed_reset();
		send_request(psa_pkg::REQ_ALLOC, 4'hf, 4'hf);
		send_request(psa_pkg::REQ_FREE, 4'd15, 4'd0);
		send_request(psa_pkg::REQ_FREE, 4'd1, 4'd15);
		free_live(0);
		for (int i = 0; i < 17; i++) send_request(psa_pkg::REQ_ALLOC, 4'(i), 4'(~i));
		// The seventeenth alloc opened block 1; hand it back to release it.
		free_live(live_slots.size() - 1);
		send_request(psa_pkg::REQ_FREE, 4'd0, 4'd15);
	endtask

	// With one node per block, after the root's node every alloc opens a block until none is left.
	task automatic test_exhaust_blocks();
		write_slots(5'd1);
		for (int i = 0; i < 17; i++) send_request(psa_pkg::REQ_ALLOC, 4'd0, 4'd0);
		send_request(psa_pkg::REQ_FREE, 4'd0, 4'd0);
		while (live_slots.size() != 0) free_live($urandom_range(0, live_slots.size() - 1));
		send_request(psa_pkg::REQ_FREE, 4'd7, 4'd3);
	endtask

	// Mostly well-formed traffic: allocs and frees of handed-out slots, with
	// some stray frees that hit unopened blocks, odd nodes or double frees.
	task automatic test_random_traffic(int unsigned count, int unsigned alloc_pct,
			bit hold_mid);
		int unsigned pick;
		for (int unsigned i = 0; i < count; i++) begin
			if (hold_mid && i == count / 2) wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_request(psa_pkg::REQ_FREE, 4'($urandom), 4'($urandom));
			else if (pick < 8 + alloc_pct || live_slots.size() == 0)
				send_request(psa_pkg::REQ_ALLOC, 4'($urandom), 4'($urandom));
			else
				free_live($urandom_range(0, live_slots.size() - 1));
		end
	endtask

	// Result checker: each delivered item against the oldest expectation.
	always @(posedge clk) begin
		slot_result_t e;
		if (rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d got %0d", e.status, status);
					fail_count++;
				end
				if (got_block !== e.blk) begin
					$error("got_block expected %0d got %0d", e.blk, got_block);
					fail_count++;
				end
				if (got_node !== e.node) begin
					$error("got_node expected %0d got %0d", e.node, got_node);
					fail_count++;
				end
				if (free_total !== e.free_total) begin
					$error("free_total expected %0d got %0d", e.free_total, free_total);
					fail_count++;
				end
				if (open_blocks !== e.open_blocks) begin
					$error("open_blocks expected %0d got %0d", e.open_blocks,
						open_blocks);
					fail_count++;
				end
			end
		end
	end

	// Receiver stalls in random bursts, none once the run goes quiet.
	initial begin
		rsp_stall = 0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_stall = 1;
				repeat ($urandom_range(1, 8) - 1) @(negedge clk);
				@(negedge clk);
				rsp_stall = 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		req_valid = 0;
		req_type = 0;
		block_slot = 0;
		node_index = 0;
		cfg_valid = 0;
		cfg_data = 0;
		pool_init(5'd16);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed_reset();
		test_exhaust_blocks();
		write_slots(5'd16);
		test_random_traffic(400, 60, 1);
		write_slots(5'd0);
		test_random_traffic(200, 50, 0);
		write_slots(5'd31);
		test_random_traffic(250, 40, 0);
		write_slots(5'd2);
		test_random_traffic(300, 55, 0);
		write_slots(5'd5);
		test_random_traffic(300, 50, 0);
		write_slots(5'd3);
		quiet = 1;
		test_random_traffic(400, 52, 0);

		wait_idle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
rtl/psa_pkg.sv
rtl/psa_node_ram.sv
rtl/pooled_slot_allocator_top.sv
tb/tb_top.sv
